### sv/crst_pkg.sv
// ----------------------------------------------------------------------------
// crst_pkg
// Shared types, codes and constants for the call/return symbol tracer.
// ----------------------------------------------------------------------------
`default_nettype none

package crst_pkg;

  // Symbol table capacity (one chain cell per entry).
  localparam int MAX_SYMBOLS = 64;
  localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);

  // Input item kinds.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_INST = 1'b1;

  // Event codes on out_event_res.
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_CALL = 2'd1;
  localparam logic [1:0] EV_RET  = 2'd2;

  // Instruction decode patterns.
  localparam logic [31:0] JAL_MASK     = 32'h0000_0FFF;
  localparam logic [31:0] JAL_RA_CALL  = 32'h0000_00EF;
  localparam logic [31:0] JALR_MASK    = 32'h0000_7FFF;
  localparam logic [31:0] JALR_RA_CALL = 32'h0000_00E7;
  localparam logic [31:0] RET_WORD     = 32'h0000_8067;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // One symbol table entry.
  typedef struct packed {
    logic [63:0] start;
    logic [63:0] length;
    logic [31:0] id;
  } sym_entry_t;

  // Lookup token that walks the cell chain.
  typedef struct packed {
    logic             valid;
    logic [63:0]      addr;
    logic [CNT_W-1:0] remaining;
    logic             found;
    logic [31:0]      id;
  } query_t;

endpackage

`default_nettype wire

### sv/crst_cell.sv
// ----------------------------------------------------------------------------
// crst_cell
// One symbol table entry plus one stage of the lookup token pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module crst_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                shift_en,
  input  wire crst_pkg::sym_entry_t entry_in,
  output crst_pkg::sym_entry_t     entry_out,
  input  wire crst_pkg::query_t    tok_in,
  output crst_pkg::query_t         tok_out
);

  crst_pkg::sym_entry_t entry_r;
  crst_pkg::query_t     tok_r;
  crst_pkg::query_t     tok_nxt;
  logic                 active;
  logic                 hit;
  logic [63:0]          offset;

  // The entry takes the one from its newer neighbor when a load shifts in.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= entry_in;
    end
  end

  assign entry_out = entry_r;

  always_comb begin
    active  = (tok_in.remaining != '0);
    offset  = tok_in.addr - entry_r.start;
    hit     = active && (tok_in.addr >= entry_r.start) && (offset < entry_r.length);
    tok_nxt = tok_in;
    if (active) begin
      tok_nxt.remaining = tok_in.remaining - crst_pkg::CNT_W'(1);
    end
    // Cells nearer the head hold newer entries, so the first hit is kept.
    if (hit && !tok_in.found) begin
      tok_nxt.found = 1'b1;
      tok_nxt.id    = entry_r.id;
    end
  end

  // Only the valid bit is reset; the payload is ignored while it is low.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.addr      <= tok_nxt.addr;
    tok_r.remaining <= tok_nxt.remaining;
    tok_r.found     <= tok_nxt.found;
    tok_r.id        <= tok_nxt.id;
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

### sv/crst_chain.sv
// ----------------------------------------------------------------------------
// crst_chain
// Row of table cells: entries shift toward the tail on load, and lookup
// tokens travel from head to tail one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module crst_chain (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 shift_en,
  input  wire crst_pkg::sym_entry_t new_entry,
  input  wire crst_pkg::query_t     tok_head,
  output crst_pkg::query_t          tok_tail
);

  crst_pkg::sym_entry_t entry_w [crst_pkg::MAX_SYMBOLS+1];
  crst_pkg::query_t     tok_w   [crst_pkg::MAX_SYMBOLS+1];

  assign entry_w[0] = new_entry;
  assign tok_w[0]   = tok_head;

  for (genvar k = 0; k < crst_pkg::MAX_SYMBOLS; k++) begin : g_cell
    crst_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (shift_en),
      .entry_in  (entry_w[k]),
      .entry_out (entry_w[k+1]),
      .tok_in    (tok_w[k]),
      .tok_out   (tok_w[k+1])
    );
  end

  // The last cell's entry output is left unused; a load into a full table is refused.
  assign tok_tail = tok_w[crst_pkg::MAX_SYMBOLS];

endmodule

`default_nettype wire

### sv/call_return_symbol_tracer_core.sv
// ----------------------------------------------------------------------------
// call_return_symbol_tracer_core
// Classifies retired instructions as calls or returns and resolves the
// looked-up address against a table of symbol ranges held in a cell chain.
// ----------------------------------------------------------------------------
// Timing: a load or a non-branching instruction gives its result in the
// cycle after acceptance; a call or return, after its token has passed each
// cell's token register and the result register. Throughput: loads and plain
// instructions every cycle; a lookup holds busy while its token walks every cell.
// Reset (synchronous, rst_n low) empties the table and returns to idle.
// Results come out as one-cycle strobes on out_valid and are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module call_return_symbol_tracer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input transaction
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_func,
  input  wire logic [63:0] in_sym_start,
  input  wire logic [63:0] in_sym_length,
  input  wire logic [31:0] in_sym_id,
  input  wire logic [31:0] in_inst,
  input  wire logic [63:0] in_pc,
  input  wire logic [63:0] in_next_pc,
  // Result transaction
  output logic             out_valid,
  output logic [1:0]       out_event_res,
  output logic             out_found,
  output logic [31:0]      out_symbol_id,
  output logic [63:0]      out_site_pc,
  output logic [63:0]      out_target_pc,
  output logic             out_load_status
);

  localparam logic [crst_pkg::CNT_W-1:0] FULL_COUNT =
    crst_pkg::CNT_W'(crst_pkg::MAX_SYMBOLS);

  // Control state.
  crst_pkg::state_t              state_r, state_nxt;
  logic [crst_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // Result register and the branch details held during a lookup.
  logic [1:0]  out_event_r, out_event_nxt;
  logic        out_found_r, out_found_nxt;
  logic [31:0] out_id_r, out_id_nxt;
  logic [63:0] out_site_r, out_site_nxt;
  logic [63:0] out_target_r, out_target_nxt;
  logic        out_status_r, out_status_nxt;
  logic [1:0]  hold_event_r, hold_event_nxt;
  logic [63:0] hold_site_r, hold_site_nxt;
  logic [63:0] hold_target_r, hold_target_nxt;

  // Chain interface.
  logic                  shift_en;
  crst_pkg::sym_entry_t  new_entry;
  crst_pkg::query_t      tok_head;
  crst_pkg::query_t      tok_tail;

  logic is_call;
  logic is_ret;
  logic table_full;

  assign is_call = ((in_inst & crst_pkg::JAL_MASK) == crst_pkg::JAL_RA_CALL) ||
                   ((in_inst & crst_pkg::JALR_MASK) == crst_pkg::JALR_RA_CALL);
  assign is_ret     = (in_inst == crst_pkg::RET_WORD);
  assign table_full = (count_r == FULL_COUNT);

  assign new_entry.start  = in_sym_start;
  assign new_entry.length = in_sym_length;
  assign new_entry.id     = in_sym_id;

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    out_valid_nxt   = 1'b0;
    out_event_nxt   = out_event_r;
    out_found_nxt   = out_found_r;
    out_id_nxt      = out_id_r;
    out_site_nxt    = out_site_r;
    out_target_nxt  = out_target_r;
    out_status_nxt  = out_status_r;
    hold_event_nxt  = hold_event_r;
    hold_site_nxt   = hold_site_r;
    hold_target_nxt = hold_target_r;
    shift_en        = 1'b0;

    tok_head.valid     = 1'b0;
    tok_head.addr      = in_next_pc;
    tok_head.remaining = '0;
    tok_head.found     = 1'b0;
    tok_head.id        = '0;

    unique case (state_r)
      crst_pkg::ST_IDLE: begin
        if (start) begin
          // Default result: every field zero.
          out_valid_nxt  = 1'b1;
          out_event_nxt  = crst_pkg::EV_NONE;
          out_found_nxt  = 1'b0;
          out_id_nxt     = '0;
          out_site_nxt   = '0;
          out_target_nxt = '0;
          out_status_nxt = 1'b0;
          if (in_func == crst_pkg::FUNC_LOAD) begin
            // The newest entry enters at the head of the chain; a full table refuses it and sets the load status.
            if (table_full) begin
              out_status_nxt = 1'b1;
            end else begin
              shift_en  = 1'b1;
              count_nxt = count_r + crst_pkg::CNT_W'(1);
            end
          end else if (is_call || is_ret) begin
            // Launch a lookup token; the result comes when it leaves the tail.
            out_valid_nxt      = 1'b0;
            tok_head.valid     = 1'b1;
            tok_head.addr      = is_call ? in_next_pc : in_pc;
            tok_head.remaining = count_r;
            hold_event_nxt     = is_call ? crst_pkg::EV_CALL : crst_pkg::EV_RET;
            hold_site_nxt      = in_pc;
            hold_target_nxt    = in_next_pc;
            state_nxt          = crst_pkg::ST_SEARCH;
          end
        end
      end
      crst_pkg::ST_SEARCH: begin
        if (tok_tail.valid) begin
          out_valid_nxt  = 1'b1;
          out_event_nxt  = hold_event_r;
          out_found_nxt  = tok_tail.found;
          out_id_nxt     = tok_tail.id;
          out_site_nxt   = hold_site_r;
          out_target_nxt = hold_target_r;
          out_status_nxt = 1'b0;
          state_nxt      = crst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = crst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crst_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_event_r   <= out_event_nxt;
    out_found_r   <= out_found_nxt;
    out_id_r      <= out_id_nxt;
    out_site_r    <= out_site_nxt;
    out_target_r  <= out_target_nxt;
    out_status_r  <= out_status_nxt;
    hold_event_r  <= hold_event_nxt;
    hold_site_r   <= hold_site_nxt;
    hold_target_r <= hold_target_nxt;
  end

  crst_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (shift_en),
    .new_entry (new_entry),
    .tok_head  (tok_head),
    .tok_tail  (tok_tail)
  );

  assign busy            = (state_r == crst_pkg::ST_SEARCH);
  assign out_valid       = out_valid_r;
  assign out_event_res   = out_event_r;
  assign out_found       = out_found_r;
  assign out_symbol_id   = out_id_r;
  assign out_site_pc     = out_site_r;
  assign out_target_pc   = out_target_r;
  assign out_load_status = out_status_r;

endmodule

`default_nettype wire
